>>> hdl/rsxc_pkg.sv
// Shared constants and types for the ROM sum/XOR checksum locator.
`timescale 1ns / 1ps
`default_nettype none

package rsxc_pkg;

   // Storage depth of the word store
   localparam int MAX_WORDS = 65536;

   // Fixed field widths
   localparam int WORD_W = 32;
   localparam int LOC_W  = 18;
   localparam int CNT_W  = 17;

   // Derived widths
   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int WL_W   = $clog2(MAX_WORDS + 1);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [WL_W-1:0]   wcount_type;
   typedef logic [LOC_W-1:0]  loc_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

>>> hdl/rsxc_if.sv
// Valid/ready channel interfaces for ROM words and checksum results.
`timescale 1ns / 1ps
`default_nettype none

interface rsxc_req_if;
   import rsxc_pkg::*;

   logic     valid;
   logic     ready;
   word_type rom_word;
   logic     last_word;

   modport source (output valid, output rom_word, output last_word, input ready);
   modport sink   (input valid, input rom_word, input last_word, output ready);
endinterface

interface rsxc_rsp_if;
   import rsxc_pkg::*;

   logic     valid;
   logic     ready;
   word_type expected_sum;
   word_type expected_xor;
   loc_type  sum_location;
   loc_type  xor_location;
   cnt_type  sum_matches;
   cnt_type  xor_matches;
   logic     status;

   modport source (output valid, output expected_sum, output expected_xor,
                   output sum_location, output xor_location, output sum_matches,
                   output xor_matches, output status, input ready);
   modport sink   (input valid, input expected_sum, input expected_xor,
                   input sum_location, input xor_location, input sum_matches,
                   input xor_matches, input status, output ready);
endinterface

`default_nettype wire

>>> hdl/rsxc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rsxc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/rom_sum_xor_checksum_locate.sv
// Top level: stores a ROM image, derives sum/XOR targets and locates them.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+---------------------------------------------
//  req_chan | in  | valid/ready  | rom_word, last_word
//  rsp_chan | out | valid/ready  | expected_sum/xor, sum/xor_location,
//           |     |              | sum/xor_matches, status
//
// Words load one per cycle into the word store while the sum and XOR run, but
// only in the load state. After the last word the store is read back through
// its single read port, one word a cycle; once the last read has been compared
// the finish state registers the result, and the input is ready again from
// that edge on.
// Reset clears the control state only; the word store is never cleared.
// A waiting result does not block loading; a new result waits in the finish
// state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module rom_sum_xor_checksum_locate (
   input wire logic   clock,
   input wire logic   reset,
   rsxc_req_if.sink   req_chan,
   rsxc_rsp_if.source rsp_chan
);
   import rsxc_pkg::*;

   state_type  state_ff, state_in;
   word_type   sum_ff, sum_in;
   word_type   xor_ff, xor_in;
   wcount_type loaded_ff, loaded_in;
   word_type   tgt_sum_ff, tgt_sum_in;
   word_type   tgt_xor_ff, tgt_xor_in;
   wcount_type scan_len_ff, scan_len_in;
   wcount_type rd_addr_ff, rd_addr_in;
   logic       rd_valid_ff, rd_valid_in;
   addr_type   rd_idx_ff, rd_idx_in;
   wcount_type sum_cnt_ff, sum_cnt_in;
   wcount_type xor_cnt_ff, xor_cnt_in;
   loc_type    sum_loc_ff, sum_loc_in;
   loc_type    xor_loc_ff, xor_loc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   out_sum_ff, out_sum_in;
   word_type   out_xor_ff, out_xor_in;
   loc_type    out_sloc_ff, out_sloc_in;
   loc_type    out_xloc_ff, out_xloc_in;
   cnt_type    out_scnt_ff, out_scnt_in;
   cnt_type    out_xcnt_ff, out_xcnt_in;
   logic       out_status_ff, out_status_in;

   logic       req_fire;
   logic       wr_en;
   logic       rd_en;
   word_type   rd_data;
   word_type   new_sum;
   word_type   new_xor;
   wcount_type new_loaded;
   logic       out_free;

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign wr_en          = req_fire && (loaded_ff < WL_W'(MAX_WORDS));
   assign new_sum        = sum_ff + req_chan.rom_word;
   assign new_xor        = xor_ff ^ req_chan.rom_word;
   assign new_loaded     = wr_en ? loaded_ff + WL_W'(1) : loaded_ff;
   assign rd_en          = (state_ff == ST_SCAN) && (rd_addr_ff < scan_len_ff);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   rsxc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (loaded_ff[ADDR_W-1:0]),
      .wr_data (req_chan.rom_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      xor_in        = xor_ff;
      loaded_in     = loaded_ff;
      tgt_sum_in    = tgt_sum_ff;
      tgt_xor_in    = tgt_xor_ff;
      scan_len_in   = scan_len_ff;
      rd_addr_in    = rd_addr_ff;
      rd_valid_in   = rd_en;
      rd_idx_in     = rd_addr_ff[ADDR_W-1:0];
      sum_cnt_in    = sum_cnt_ff;
      xor_cnt_in    = xor_cnt_ff;
      sum_loc_in    = sum_loc_ff;
      xor_loc_in    = xor_loc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_sum_in    = out_sum_ff;
      out_xor_in    = out_xor_ff;
      out_sloc_in   = out_sloc_ff;
      out_xloc_in   = out_xloc_ff;
      out_scnt_in   = out_scnt_ff;
      out_xcnt_in   = out_xcnt_ff;
      out_status_in = out_status_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               sum_in    = new_sum;
               xor_in    = new_xor;
               loaded_in = new_loaded;
               if (req_chan.last_word) begin
                  // capture targets and restart the running state for the next image
                  tgt_sum_in  = new_xor;
                  tgt_xor_in  = new_sum - {new_xor[WORD_W-2:0], 1'b0};
                  scan_len_in = new_loaded;
                  sum_in      = '0;
                  xor_in      = '0;
                  loaded_in   = '0;
                  rd_addr_in  = '0;
                  sum_cnt_in  = '0;
                  xor_cnt_in  = '0;
                  sum_loc_in  = '0;
                  xor_loc_in  = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               rd_addr_in = rd_addr_ff + WL_W'(1);
            end
            if (rd_valid_ff) begin
               if (rd_data == tgt_sum_ff) begin
                  sum_loc_in = LOC_W'({rd_idx_ff, 2'b00});
                  if (sum_cnt_ff < WL_W'(MAX_WORDS)) begin
                     sum_cnt_in = sum_cnt_ff + WL_W'(1);
                  end
               end
               if (rd_data == tgt_xor_ff) begin
                  xor_loc_in = LOC_W'({rd_idx_ff, 2'b00});
                  if (xor_cnt_ff < WL_W'(MAX_WORDS)) begin
                     xor_cnt_in = xor_cnt_ff + WL_W'(1);
                  end
               end
            end
            if (!rd_en && !rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_sum_in    = tgt_sum_ff;
               out_xor_in    = tgt_xor_ff;
               out_sloc_in   = sum_loc_ff;
               out_xloc_in   = xor_loc_ff;
               out_scnt_in   = CNT_W'(sum_cnt_ff);
               out_xcnt_in   = CNT_W'(xor_cnt_ff);
               out_status_in = (sum_cnt_ff == '0) && (xor_cnt_ff == '0);
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         sum_ff       <= '0;
         xor_ff       <= '0;
         loaded_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         xor_ff       <= xor_in;
         loaded_ff    <= loaded_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_sum_ff    <= tgt_sum_in;
      tgt_xor_ff    <= tgt_xor_in;
      scan_len_ff   <= scan_len_in;
      rd_addr_ff    <= rd_addr_in;
      rd_idx_ff     <= rd_idx_in;
      sum_cnt_ff    <= sum_cnt_in;
      xor_cnt_ff    <= xor_cnt_in;
      sum_loc_ff    <= sum_loc_in;
      xor_loc_ff    <= xor_loc_in;
      out_sum_ff    <= out_sum_in;
      out_xor_ff    <= out_xor_in;
      out_sloc_ff   <= out_sloc_in;
      out_xloc_ff   <= out_xloc_in;
      out_scnt_ff   <= out_scnt_in;
      out_xcnt_ff   <= out_xcnt_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.expected_sum = out_sum_ff;
   assign rsp_chan.expected_xor = out_xor_ff;
   assign rsp_chan.sum_location = out_sloc_ff;
   assign rsp_chan.xor_location = out_xloc_ff;
   assign rsp_chan.sum_matches  = out_scnt_ff;
   assign rsp_chan.xor_matches  = out_xcnt_ff;
   assign rsp_chan.status       = out_status_ff;

   // read data only ever returns during the search
   a_rd_in_scan : assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("store read data outside search");

   a_last_starts_scan : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.last_word) |=> (state_ff == ST_SCAN))
      else $error("last word did not start search");

   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (sum_cnt_ff <= scan_len_ff && xor_cnt_ff <= scan_len_ff))
      else $error("match count exceeds stored words");

endmodule

`default_nettype wire

>>> verif/tb_rom_sum_xor_checksum_locate.sv
// Self-checking testbench for the ROM sum/XOR checksum locator.
`timescale 1ns / 1ps

module tb_rom_sum_xor_checksum_locate;
   import rsxc_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int DIRECTED_ROWS = 18;

   typedef struct {
      word_type exp_sum;
      word_type exp_xor;
      loc_type  sum_loc;
      loc_type  xor_loc;
      cnt_type  sum_cnt;
      cnt_type  xor_cnt;
      logic     status;
   } checksum_result_type;

   typedef struct {
      logic                pinned;
      checksum_result_type want;
   } pin_entry_type;

   typedef struct {
      word_type            word;
      logic                last;
      logic                pinned;
      checksum_result_type want;
   } stim_row_type;

   localparam checksum_result_type NO_PIN =
      '{32'h0, 32'h0, 18'd0, 18'd0, 17'd0, 17'd0, 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsxc_req_if req_bus ();
   rsxc_rsp_if rsp_bus ();

   rom_sum_xor_checksum_locate DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // Predictor state for the image being loaded
   word_type            image_words[$];
   word_type            image_sum;
   word_type            image_xor;
   checksum_result_type pending_results[$];
   pin_entry_type       pin_queue[$];

   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 7;
   int unsigned recv_idle_pct = 85;
   int unsigned hold_left     = 0;
   bit          hold_req      = 1'b0;

   // Known answers where they follow directly from the definition
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'h00000000, 1'b1, 1'b1,
        '{32'h00000000, 32'h00000000, 18'd0, 18'd0, 17'd1, 17'd1, 1'b0}},
      '{32'hFFFFFFFF, 1'b1, 1'b1,
        '{32'hFFFFFFFF, 32'h00000001, 18'd0, 18'd0, 17'd1, 17'd0, 1'b0}},
      '{32'h00000001, 1'b0, 1'b0, NO_PIN},
      '{32'h00000002, 1'b1, 1'b1,
        '{32'h00000003, 32'hFFFFFFFD, 18'd0, 18'd0, 17'd0, 17'd0, 1'b1}},
      '{32'h00000005, 1'b0, 1'b0, NO_PIN},
      '{32'h00000005, 1'b0, 1'b0, NO_PIN},
      '{32'h00000005, 1'b1, 1'b1,
        '{32'h00000005, 32'h00000005, 18'd8, 18'd8, 17'd3, 17'd3, 1'b0}},
      '{32'hAAAAAAAA, 1'b0, 1'b0, NO_PIN},
      '{32'h55555555, 1'b1, 1'b1,
        '{32'hFFFFFFFF, 32'h00000001, 18'd0, 18'd0, 17'd0, 17'd0, 1'b1}},
      '{32'h80000000, 1'b0, 1'b0, NO_PIN},
      '{32'h7FFFFFFF, 1'b0, 1'b0, NO_PIN},
      '{32'h12345678, 1'b0, 1'b0, NO_PIN},
      '{32'hDEADBEEF, 1'b1, 1'b0, NO_PIN},
      '{32'h00000003, 1'b0, 1'b0, NO_PIN},
      '{32'h00000001, 1'b0, 1'b0, NO_PIN},
      '{32'h00000002, 1'b1, 1'b0, NO_PIN},
      '{32'hC0FFEE00, 1'b0, 1'b0, NO_PIN},
      '{32'h3F0011FF, 1'b1, 1'b0, NO_PIN}
   };

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %s: got 0x%0h expected 0x%0h", what, got, want);
      error_count++;
   endtask

   // Fold one accepted word into the image; on the last word derive the result
   task automatic absorb_rom_word(word_type word, logic last);
      pin_entry_type       pin;
      checksum_result_type res;
      word_type            target_sum;
      word_type            target_xor;
      int unsigned         sum_hits;
      int unsigned         xor_hits;
      int unsigned         sum_off;
      int unsigned         xor_off;
      pin = pin_queue.pop_front();
      if (image_words.size() < MAX_WORDS) image_words.push_back(word);
      image_sum = image_sum + word;
      image_xor = image_xor ^ word;
      if (last) begin
         target_sum = image_xor;
         target_xor = image_sum - (image_xor << 1);
         sum_hits = 0;
         xor_hits = 0;
         sum_off  = 0;
         xor_off  = 0;
         foreach (image_words[i]) begin
            if (image_words[i] == target_sum) begin
               sum_off = i * 4;
               if (sum_hits < MAX_WORDS) sum_hits++;
            end
            if (image_words[i] == target_xor) begin
               xor_off = i * 4;
               if (xor_hits < MAX_WORDS) xor_hits++;
            end
         end
         res.exp_sum = target_sum;
         res.exp_xor = target_xor;
         res.sum_loc = loc_type'(sum_off);
         res.xor_loc = loc_type'(xor_off);
         res.sum_cnt = cnt_type'(sum_hits);
         res.xor_cnt = cnt_type'(xor_hits);
         res.status  = (sum_hits == 0 && xor_hits == 0);
         pending_results.push_back(pin.pinned ? pin.want : res);
         image_words.delete();
         image_sum = '0;
         image_xor = '0;
      end
   endtask

   task automatic check_checksum_result();
      checksum_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with none expected", rsp_bus.expected_sum, 32'h0);
      end else begin
         want = pending_results.pop_front();
         if (rsp_bus.expected_sum !== want.exp_sum)
            report_mismatch("expected_sum", rsp_bus.expected_sum, want.exp_sum);
         if (rsp_bus.expected_xor !== want.exp_xor)
            report_mismatch("expected_xor", rsp_bus.expected_xor, want.exp_xor);
         if (rsp_bus.sum_location !== want.sum_loc)
            report_mismatch("sum_location", rsp_bus.sum_location, want.sum_loc);
         if (rsp_bus.xor_location !== want.xor_loc)
            report_mismatch("xor_location", rsp_bus.xor_location, want.xor_loc);
         if (rsp_bus.sum_matches !== want.sum_cnt)
            report_mismatch("sum_matches", rsp_bus.sum_matches, want.sum_cnt);
         if (rsp_bus.xor_matches !== want.xor_cnt)
            report_mismatch("xor_matches", rsp_bus.xor_matches, want.xor_cnt);
         if (rsp_bus.status !== want.status)
            report_mismatch("status", rsp_bus.status, want.status);
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         absorb_rom_word(req_bus.rom_word, req_bus.last_word);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         check_checksum_result();
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rom_sum_xor_checksum_locate: mismatch");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken
   task automatic push_word(word_type word, logic last, logic pinned,
                            checksum_result_type want);
      pin_entry_type pin;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      pin.pinned = pinned;
      pin.want   = want;
      pin_queue.push_back(pin);
      req_bus.valid     <= 1'b1;
      req_bus.rom_word  <= word;
      req_bus.last_word <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_random_images(int budget);
      word_type image[$];
      word_type pool[4];
      word_type fold;
      int       sent;
      int       len;
      int       pick;
      int       flavor;
      int       k;
      pool = '{32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h80000000};
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 80)      len = $urandom_range(12, 1);
         else if (pick < 95) len = $urandom_range(40, 13);
         else                len = $urandom_range(64, 41);
         flavor = $urandom_range(9);
         image.delete();
         for (k = 0; k < len; k++) begin
            if (flavor >= 4 && flavor <= 6) image.push_back(pool[$urandom_range(3)]);
            else                            image.push_back($urandom);
         end
         // Plant a sum target: pick the last word so the total XOR equals a stored word
         if (flavor >= 7 && len >= 2) begin
            fold = '0;
            for (k = 0; k < len - 1; k++) fold = fold ^ image[k];
            k = $urandom_range(len - 2);
            image[len-1] = image[k] ^ fold;
         end
         for (k = 0; k < len; k++) push_word(image[k], k == len - 1, 1'b0, NO_PIN);
         sent += len;
      end
   endtask

   initial begin
      image_sum         = '0;
      image_xor         = '0;
      req_bus.valid     = 1'b0;
      req_bus.rom_word  = '0;
      req_bus.last_word = 1'b0;
      rsp_bus.ready     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         push_word(directed_rows[i].word, directed_rows[i].last,
                   directed_rows[i].pinned, directed_rows[i].want);
      send_random_images(220);

      send_idle_pct = 85;
      recv_idle_pct = 7;
      send_random_images(220);

      // Hold the result side off while words keep coming so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req      = 1'b1;
      send_random_images(210);
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("rom_sum_xor_checksum_locate: match");
      else
         $display("rom_sum_xor_checksum_locate: mismatch");
      $finish;
   end

endmodule
